// ----- hw/rtl/line_segment_clipper_assert.svh -----
// Assertion helpers for the clipper RTL
`ifndef LINE_SEGMENT_CLIPPER_ASSERT_SVH
`define LINE_SEGMENT_CLIPPER_ASSERT_SVH

// same-cycle implication, off while reset is low
`define LSC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("line_segment_clipper: implication check failed");

// next-cycle implication, off while reset is low
`define LSC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("line_segment_clipper: next-cycle check failed");

`endif

// ----- hw/rtl/lsc_pkg.sv -----
`timescale 1ns / 1ps

package lsc_pkg;

    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIN_X_MIN = 2'd0,
        CFG_WIN_X_MAX = 2'd1,
        CFG_WIN_Y_MIN = 2'd2,
        CFG_WIN_Y_MAX = 2'd3
    } cfg_index_t;

endpackage

// ----- hw/rtl/line_segment_clipper.sv -----
`timescale 1ns / 1ps
//  channel   | direction | payload (low bit first)
//  ----------+-----------+------------------------------------------------------
//  s_axis    | in        | start_x, start_y, end_x, end_y
//  m_axis    | out       | visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y
//  cfg       | in        | win_x_min, win_x_max, win_y_min, win_y_max by index
//
//  One segment enters per cycle while the output is not stalled; the restoring
//  dividers resolve one quotient bit per stage.
//  Reset is synchronous, active low; it clears valid bits and loads the window.
//  When m_tready is low with a result waiting, the whole pipeline holds.
//  Bubbles travel as invalid stages and are not squeezed out.

`include "line_segment_clipper_assert.svh"

module line_segment_clipper #(
    parameter int COORD_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y
    output logic [((4*COORD_BITS+8)/8)*8-1:0] m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [lsc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]             cfg_data
);

    localparam int N     = COORD_BITS;
    localparam int OUT_W = ((4*COORD_BITS+8)/8)*8;
    localparam logic [N-1:0] WIN_MAX_RESET = N'((64'd1 << (N-1)) - 64'd1);

    typedef struct packed {
        logic [N-1:0] rem;
        logic [N-1:0] low;
        logic [N-1:0] quo;
        logic [N-1:0] den;
    } lane_t;

    function automatic lane_t div_step(lane_t a);
        logic [N:0] r2;
        lane_t      b;
        logic       qbit;
        b    = a;
        r2   = {a.rem, a.low[N-1]};
        qbit = (r2 >= {1'b0, a.den});
        if (qbit) begin
            b.rem = N'(r2 - {1'b0, a.den});
        end else begin
            b.rem = r2[N-1:0];
        end
        b.low = {a.low[N-2:0], 1'b0};
        b.quo = {a.quo[N-2:0], qbit};
        return b;
    endfunction

    function automatic logic [N-1:0] settle(logic signed [N-1:0] a, logic neg,
                                            logic [N-1:0] q, logic [N-1:0] r);
        logic signed [N+1:0] s;
        s = neg ? ((N+2)'(a) - $signed({2'b00, q})) : ((N+2)'(a) + $signed({2'b00, q}));
        if (r != '0) begin
            if (!neg && s < 0) begin
                s = s + (N+2)'(1);
            end else if (neg && s > 0) begin
                s = s - (N+2)'(1);
            end
        end
        return s[N-1:0];
    endfunction

    // window registers
    logic signed [N-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg <= '0;
            x_max_reg <= WIN_MAX_RESET;
            y_min_reg <= '0;
            y_max_reg <= WIN_MAX_RESET;
        end else if (cfg_we) begin
            case (lsc_pkg::cfg_index_t'(cfg_index))
                lsc_pkg::CFG_WIN_X_MIN: x_min_reg <= cfg_data;
                lsc_pkg::CFG_WIN_X_MAX: x_max_reg <= cfg_data;
                lsc_pkg::CFG_WIN_Y_MIN: y_min_reg <= cfg_data;
                lsc_pkg::CFG_WIN_Y_MAX: y_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic advance;
    logic m_tvalid_reg;
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // stage 0: deltas, edge distances, candidate fractions
    logic signed [N-1:0] in_x1, in_y1, in_x2, in_y2;
    logic signed [N:0]   dx_c, dy_c, q0, q1, q2, q3;
    logic signed [N:0]   ent_x, ent_y, ext_x, ext_y;
    logic [N-1:0]        dmx, dmy;
    logic                rej_c, use_ex, use_ey, use_xx, use_xy;

    assign in_x1 = s_tdata[N-1:0];
    assign in_y1 = s_tdata[2*N-1:N];
    assign in_x2 = s_tdata[3*N-1:2*N];
    assign in_y2 = s_tdata[4*N-1:3*N];

    always_comb begin
        dx_c  = (N+1)'(in_x2) - (N+1)'(in_x1);
        dy_c  = (N+1)'(in_y2) - (N+1)'(in_y1);
        q0    = (N+1)'(in_x1) - (N+1)'(x_min_reg);
        q1    = (N+1)'(x_max_reg) - (N+1)'(in_x1);
        q2    = (N+1)'(in_y1) - (N+1)'(y_min_reg);
        q3    = (N+1)'(y_max_reg) - (N+1)'(in_y1);
        dmx   = dx_c[N] ? N'(-dx_c) : dx_c[N-1:0];
        dmy   = dy_c[N] ? N'(-dy_c) : dy_c[N-1:0];
        ent_x = (dx_c > 0) ? -q0 : -q1;
        ent_y = (dy_c > 0) ? -q2 : -q3;
        ext_x = (dx_c > 0) ? q1 : q0;
        ext_y = (dy_c > 0) ? q3 : q2;
        // parallel edge outside, or leaving before the start
        rej_c = (dx_c >= 0 && q1 < 0) || (dx_c <= 0 && q0 < 0) ||
                (dy_c >= 0 && q3 < 0) || (dy_c <= 0 && q2 < 0);
        use_ex = (dx_c != 0) && !ent_x[N];
        use_ey = (dy_c != 0) && !ent_y[N];
        use_xx = (dx_c != 0) && !ext_x[N] && (ext_x[N-1:0] < dmx);
        use_xy = (dy_c != 0) && !ext_y[N] && (ext_y[N-1:0] < dmy);
    end

    // stage 1
    logic              v1_reg, rej1_reg;
    logic signed [N-1:0] x1_1_reg, y1_1_reg;
    logic signed [N:0] dx1_reg, dy1_reg;
    logic [N-1:0]      exn_reg, exd_reg, eyn_reg, eyd_reg;
    logic [N-1:0]      xxn_reg, xxd_reg, xyn_reg, xyd_reg;

    // stage 2
    logic              v2_reg, rej2_reg;
    logic signed [N-1:0] x1_2_reg, y1_2_reg;
    logic signed [N:0] dx2_reg, dy2_reg;
    logic [N-1:0]      exn2_reg, exd2_reg, eyn2_reg, eyd2_reg;
    logic [N-1:0]      xxn2_reg, xxd2_reg, xyn2_reg, xyd2_reg;
    logic [2*N-1:0]    pea_reg, peb_reg, pxa_reg, pxb_reg;

    // stage 3
    logic              v3_reg, rej3_reg;
    logic signed [N-1:0] x1_3_reg, y1_3_reg;
    logic              sx3_reg, sy3_reg;
    logic [N-1:0]      mx3_reg, my3_reg;
    logic [N-1:0]      en3_reg, ed3_reg, xn3_reg, xd3_reg;

    // stage 4
    logic              v4_reg, rej4_reg;
    logic signed [N-1:0] x1_4_reg, y1_4_reg;
    logic              sx4_reg, sy4_reg;
    logic [N-1:0]      ed4_reg, xd4_reg;
    logic [2*N-1:0]    pva_reg, pvb_reg, psx_reg, psy_reg, pex_reg, pey_reg;

    // divider stages
    lane_t             dv_lane_reg [0:N][4];
    logic              dv_v_reg    [0:N];
    logic              dv_vis_reg  [0:N];
    logic signed [N-1:0] dv_x1_reg [0:N];
    logic signed [N-1:0] dv_y1_reg [0:N];
    logic              dv_sx_reg   [0:N];
    logic              dv_sy_reg   [0:N];

    logic [OUT_W-1:0]  m_tdata_reg;
    logic [OUT_W-1:0]  m_tdata_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k <= N; k++) begin
                dv_v_reg[k] <= 1'b0;
            end
        end else if (advance) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            dv_v_reg[0]  <= v4_reg;
            for (int k = 1; k <= N; k++) begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
            m_tvalid_reg <= dv_v_reg[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rej1_reg <= rej_c;
            x1_1_reg <= in_x1;
            y1_1_reg <= in_y1;
            dx1_reg  <= dx_c;
            dy1_reg  <= dy_c;
            exn_reg  <= use_ex ? ent_x[N-1:0] : '0;
            exd_reg  <= use_ex ? dmx : N'(1);
            eyn_reg  <= use_ey ? ent_y[N-1:0] : '0;
            eyd_reg  <= use_ey ? dmy : N'(1);
            xxn_reg  <= use_xx ? ext_x[N-1:0] : N'(1);
            xxd_reg  <= use_xx ? dmx : N'(1);
            xyn_reg  <= use_xy ? ext_y[N-1:0] : N'(1);
            xyd_reg  <= use_xy ? dmy : N'(1);

            rej2_reg <= rej1_reg;
            x1_2_reg <= x1_1_reg;
            y1_2_reg <= y1_1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            exn2_reg <= exn_reg;
            exd2_reg <= exd_reg;
            eyn2_reg <= eyn_reg;
            eyd2_reg <= eyd_reg;
            xxn2_reg <= xxn_reg;
            xxd2_reg <= xxd_reg;
            xyn2_reg <= xyn_reg;
            xyd2_reg <= xyd_reg;
            pea_reg  <= exn_reg * eyd_reg;
            peb_reg  <= eyn_reg * exd_reg;
            pxa_reg  <= xxn_reg * xyd_reg;
            pxb_reg  <= xyn_reg * xxd_reg;

            // keep the later entry and the earlier exit
            rej3_reg <= rej2_reg;
            x1_3_reg <= x1_2_reg;
            y1_3_reg <= y1_2_reg;
            sx3_reg  <= dx2_reg[N];
            sy3_reg  <= dy2_reg[N];
            mx3_reg  <= dx2_reg[N] ? N'(-dx2_reg) : dx2_reg[N-1:0];
            my3_reg  <= dy2_reg[N] ? N'(-dy2_reg) : dy2_reg[N-1:0];
            en3_reg  <= (peb_reg > pea_reg) ? eyn2_reg : exn2_reg;
            ed3_reg  <= (peb_reg > pea_reg) ? eyd2_reg : exd2_reg;
            xn3_reg  <= (pxb_reg < pxa_reg) ? xyn2_reg : xxn2_reg;
            xd3_reg  <= (pxb_reg < pxa_reg) ? xyd2_reg : xxd2_reg;

            rej4_reg <= rej3_reg;
            x1_4_reg <= x1_3_reg;
            y1_4_reg <= y1_3_reg;
            sx4_reg  <= sx3_reg;
            sy4_reg  <= sy3_reg;
            ed4_reg  <= ed3_reg;
            xd4_reg  <= xd3_reg;
            pva_reg  <= xn3_reg * ed3_reg;
            pvb_reg  <= en3_reg * xd3_reg;
            psx_reg  <= en3_reg * mx3_reg;
            psy_reg  <= en3_reg * my3_reg;
            pex_reg  <= xn3_reg * mx3_reg;
            pey_reg  <= xn3_reg * my3_reg;

            // load dividers; high half is below the divisor since t <= 1
            dv_vis_reg[0] <= !rej4_reg && (pva_reg > pvb_reg);
            dv_x1_reg[0]  <= x1_4_reg;
            dv_y1_reg[0]  <= y1_4_reg;
            dv_sx_reg[0]  <= sx4_reg;
            dv_sy_reg[0]  <= sy4_reg;
            dv_lane_reg[0][0] <= '{rem: psx_reg[2*N-1:N], low: psx_reg[N-1:0],
                                   quo: '0, den: ed4_reg};
            dv_lane_reg[0][1] <= '{rem: psy_reg[2*N-1:N], low: psy_reg[N-1:0],
                                   quo: '0, den: ed4_reg};
            dv_lane_reg[0][2] <= '{rem: pex_reg[2*N-1:N], low: pex_reg[N-1:0],
                                   quo: '0, den: xd4_reg};
            dv_lane_reg[0][3] <= '{rem: pey_reg[2*N-1:N], low: pey_reg[N-1:0],
                                   quo: '0, den: xd4_reg};

            for (int k = 1; k <= N; k++) begin
                dv_vis_reg[k] <= dv_vis_reg[k-1];
                dv_x1_reg[k]  <= dv_x1_reg[k-1];
                dv_y1_reg[k]  <= dv_y1_reg[k-1];
                dv_sx_reg[k]  <= dv_sx_reg[k-1];
                dv_sy_reg[k]  <= dv_sy_reg[k-1];
                for (int j = 0; j < 4; j++) begin
                    dv_lane_reg[k][j] <= div_step(dv_lane_reg[k-1][j]);
                end
            end

            m_tdata_reg <= m_tdata_next;
        end
    end

    // truncate toward zero, drop coordinates of a segment that is not visible
    always_comb begin
        if (dv_vis_reg[N]) begin
            m_tdata_next = OUT_W'({
                settle(dv_y1_reg[N], dv_sy_reg[N], dv_lane_reg[N][3].quo,
                       dv_lane_reg[N][3].rem),
                settle(dv_x1_reg[N], dv_sx_reg[N], dv_lane_reg[N][2].quo,
                       dv_lane_reg[N][2].rem),
                settle(dv_y1_reg[N], dv_sy_reg[N], dv_lane_reg[N][1].quo,
                       dv_lane_reg[N][1].rem),
                settle(dv_x1_reg[N], dv_sx_reg[N], dv_lane_reg[N][0].quo,
                       dv_lane_reg[N][0].rem),
                1'b1});
        end else begin
            m_tdata_next = '0;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    `LSC_ASSERT_IMP(a_hidden_zero, aclk, aresetn,
                    m_tvalid_reg && !m_tdata_reg[0], m_tdata_reg == '0)
    `LSC_ASSERT_NXT(a_stall_holds_s1, aclk, aresetn, !advance, $stable(v1_reg) && $stable(exn_reg))
    `LSC_ASSERT_NXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, v1_reg)
    `LSC_ASSERT_IMP(a_rej_hidden, aclk, aresetn,
                    dv_v_reg[0] && $past(rej4_reg) && $past(advance), !dv_vis_reg[0])

endmodule
